// ----- src/assert_macros.svh -----
// Assertion macros shared by the gap buffer store RTL.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that implies another in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- src/gbts_pkg.sv -----
// Package for the gap buffer text store: command codes, field widths and the
// control/status structs passed between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package gbts_pkg;

  // Default store capacity in bytes.
  localparam int CAPACITY_DEF = 4096;

  // Fixed widths of the stream fields.
  localparam int CMD_W     = 3;
  localparam int CHAR_W    = 8;
  localparam int POS_W     = 12;
  localparam int COUNT_W   = 13;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_LEFT   = 3'd2,
    CMD_RIGHT  = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // input word taken this cycle, store read issued
    logic commit;  // apply the command and load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;  // result register holds a word that is not taken this cycle
  } dp_status_t;

endpackage

// ----- src/gbts_ctrl.sv -----
// Controller for the gap buffer text store: a two-state sequencer that takes a
// command word, then commits it once the result register can accept. Uses gbts_pkg.
`timescale 1ns / 1ps

module gbts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  gbts_pkg::dp_status_t sts,
  output gbts_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Handshake and commands to the datapath.
  assign in_tready  = (state_r == S_IDLE);
  assign cmd.accept = in_tvalid && in_tready;
  assign cmd.commit = (state_r == S_EXEC) && !sts.out_busy;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/gbts_dpath.sv -----
// Datapath for the gap buffer text store: gap pointers, the byte store with a
// registered read port, and the result register. Uses gbts_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gbts_dpath #(
  parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [gbts_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [gbts_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  gbts_pkg::ctrl_cmd_t               cmd,
  output gbts_pkg::dp_status_t              sts
);

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int CW = ((PW > gbts_pkg::POS_W) ? PW : gbts_pkg::POS_W) + 1;
  localparam int OW = (PW > gbts_pkg::COUNT_W) ? PW : gbts_pkg::COUNT_W;
  localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

  // Unpacked input fields.
  logic [gbts_pkg::CMD_W-1:0]  in_cmd;
  logic [gbts_pkg::CHAR_W-1:0] in_char;
  logic [gbts_pkg::POS_W-1:0]  in_pos;

  assign in_cmd  = in_tdata[2:0];
  assign in_char = in_tdata[10:3];
  assign in_pos  = in_tdata[22:11];

  // Store and state.
  logic [7:0]                   mem_r [CAPACITY];
  logic [PW-1:0]                gap_start_r;
  logic [PW-1:0]                gap_end_r;
  logic [gbts_pkg::CMD_W-1:0]   cmd_r;
  logic [gbts_pkg::CHAR_W-1:0]  char_r;
  logic [gbts_pkg::POS_W-1:0]   pos_r;
  logic [7:0]                   rdata_r;

  // Result register.
  logic                         out_valid_r;
  logic                         ok_r;
  logic [gbts_pkg::CHAR_W-1:0]  char_out_r;
  logic [gbts_pkg::COUNT_W-1:0] cursor_r;
  logic [gbts_pkg::COUNT_W-1:0] length_r;

  // Read address chosen from the incoming word.
  logic [PW-1:0] gs_dec;
  logic [CW-1:0] pos_ext;
  logic [CW-1:0] idx;
  logic [AW-1:0] raddr;

  assign gs_dec  = gap_start_r - PW'(1);
  assign pos_ext = CW'(in_pos);

  // A logical position past the cursor is shifted over the gap.
  always_comb begin
    if (pos_ext < CW'(gap_start_r)) begin
      idx = pos_ext;
    end else begin
      idx = pos_ext + CW'(gap_end_r) - CW'(gap_start_r);
    end
  end

  always_comb begin
    case (in_cmd)
      gbts_pkg::CMD_LEFT:  raddr = gs_dec[AW-1:0];
      gbts_pkg::CMD_RIGHT: raddr = gap_end_r[AW-1:0];
      default:             raddr = idx[AW-1:0];
    endcase
  end

  // Command evaluation in the commit cycle.
  logic [PW-1:0]                len_cur;
  logic [PW-1:0]                gs_nxt;
  logic [PW-1:0]                ge_nxt;
  logic [PW-1:0]                ge_dec;
  logic [PW-1:0]                len_nxt;
  logic                         ok_nxt;
  logic [gbts_pkg::CHAR_W-1:0]  rd_nxt;
  logic                         we;
  logic [AW-1:0]                waddr;
  logic [7:0]                   wdata;
  logic [OW-1:0]                cursor_ext;
  logic [OW-1:0]                length_ext;

  assign len_cur = gap_start_r + (CAP_P - gap_end_r);
  assign ge_dec  = gap_end_r - PW'(1);

  always_comb begin
    gs_nxt = gap_start_r;
    ge_nxt = gap_end_r;
    ok_nxt = 1'b0;
    rd_nxt = '0;
    we     = 1'b0;
    waddr  = gap_start_r[AW-1:0];
    wdata  = char_r;
    case (cmd_r)
      gbts_pkg::CMD_INSERT: begin
        if (gap_start_r != gap_end_r) begin
          we     = 1'b1;
          gs_nxt = gap_start_r + PW'(1);
          ok_nxt = 1'b1;
        end
      end
      gbts_pkg::CMD_DELETE: begin
        if (gap_start_r != '0) begin
          gs_nxt = gs_dec;
          ok_nxt = 1'b1;
        end
      end
      gbts_pkg::CMD_LEFT: begin
        // The byte before the gap moves to the slot just below the gap end.
        if (gap_start_r != '0 && gap_end_r != '0) begin
          we     = 1'b1;
          waddr  = ge_dec[AW-1:0];
          wdata  = rdata_r;
          gs_nxt = gs_dec;
          ge_nxt = ge_dec;
          ok_nxt = 1'b1;
        end
      end
      gbts_pkg::CMD_RIGHT: begin
        // The byte after the gap moves to the slot at the gap start.
        if (gap_end_r != CAP_P && gap_start_r != CAP_P) begin
          we     = 1'b1;
          wdata  = rdata_r;
          gs_nxt = gap_start_r + PW'(1);
          ge_nxt = gap_end_r + PW'(1);
          ok_nxt = 1'b1;
        end
      end
      gbts_pkg::CMD_READ: begin
        if (CW'(pos_r) < CW'(len_cur)) begin
          ok_nxt = 1'b1;
          rd_nxt = rdata_r;
        end
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  assign len_nxt    = gs_nxt + (CAP_P - ge_nxt);
  assign cursor_ext = OW'(gs_nxt);
  assign length_ext = OW'(len_nxt);

  // Store write port and registered read port.
  always_ff @(posedge clk) begin
    if (cmd.commit && we) begin
      mem_r[waddr] <= wdata;
    end
    if (cmd.accept) begin
      rdata_r <= mem_r[raddr];
    end
  end

  // Latched command word.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r  <= in_cmd;
      char_r <= in_char;
      pos_r  <= in_pos;
    end
  end

  // Gap pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_start_r <= '0;
      gap_end_r   <= CAP_P;
    end else if (cmd.commit) begin
      gap_start_r <= gs_nxt;
      gap_end_r   <= ge_nxt;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ok_r       <= ok_nxt;
      char_out_r <= rd_nxt;
      cursor_r   <= cursor_ext[gbts_pkg::COUNT_W-1:0];
      length_r   <= length_ext[gbts_pkg::COUNT_W-1:0];
    end
  end

  assign sts.out_busy = out_valid_r && !out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {5'd0, length_r, cursor_r, char_out_r, ok_r};

  // Checks on the gap and on the hand-over to the result register.
  `ASSERT_ALWAYS(a_gap_order, gap_start_r <= gap_end_r, "gap start beyond gap end")
  `ASSERT_ALWAYS(a_gap_bound, gap_end_r <= CAP_P, "gap end beyond capacity")
  `ASSERT_IMPLIES(a_no_overwrite, cmd.commit, !(out_valid_r && !out_tready), "result overwritten")
  `ASSERT_IMPLIES(a_one_phase, cmd.accept, !cmd.commit, "accept and commit together")

endmodule

// ----- src/gap_buffer_text_store_core.sv -----
// Top level of the gap buffer text store: joins controller and datapath.
// Uses gbts_pkg, gbts_ctrl and gbts_dpath.
`timescale 1ns / 1ps

// Each command word is handled in the idle and then the exec state: in the
// first the word is taken and the single-port byte store is read, in the
// second the store is written back (insert, or the byte moved across the
// gap) and the result word is loaded into the output register. The store's
// one port is used once for the read and once for the write; a further word
// is held off until the commit, and the commit waits while a result word is
// still waiting to be taken. Store contents are undefined after reset and
// need no clearing pass: only bytes that were written first can be reached.
// Every command gives exactly one result word.
module gap_buffer_text_store_core #(
  parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // command[2:0], char_in[10:3], position[22:11], zero fill above
  input  logic [gbts_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // ok[0], char_out[8:1], cursor[21:9], text_length[34:22], zero fill above
  output logic [gbts_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready
);

  gbts_pkg::ctrl_cmd_t  cmd;
  gbts_pkg::dp_status_t sts;

  // Sequencer.
  gbts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Pointers, store and result register.
  gbts_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// ----- sim/tb_gap_buffer_text_store_core.sv -----
// Testbench for gap_buffer_text_store_core: drives editing commands on the input stream
// and checks every result word against a predictor of the gap buffer. Depends on gbts_pkg.
`timescale 1ns / 1ps

module tb_gap_buffer_text_store_core;

  localparam int CAP          = gbts_pkg::CAPACITY_DEF;
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_WORDS = 250;
  localparam int FILL_BYTES   = 48;

  // Field types of one command word.
  typedef logic [gbts_pkg::CMD_W-1:0]  cmd_bits_t;
  typedef logic [gbts_pkg::CHAR_W-1:0] char_t;
  typedef logic [gbts_pkg::POS_W-1:0]  pos_t;

  // One result word, split into its fields.
  typedef struct packed {
    logic                         ok;
    logic [gbts_pkg::CHAR_W-1:0]  char_out;
    logic [gbts_pkg::COUNT_W-1:0] cursor;
    logic [gbts_pkg::COUNT_W-1:0] text_length;
  } edit_result_t;

  logic                            clk;
  logic                            rst_n;
  logic [gbts_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [gbts_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tvalid;
  logic                            out_tready;

  // Predictor state: a mirror of the byte store and the two gap pointers.
  logic [gbts_pkg::CHAR_W-1:0] text_mirror [CAP];
  int unsigned                 gap_lo;
  int unsigned                 gap_hi;
  edit_result_t                pending_results [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned error_count;
  int unsigned stall_count;

  gap_buffer_text_store_core #(
    .CAPACITY(CAP)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned text_len_model();
    return gap_lo + (CAP - gap_hi);
  endfunction

  // Apply one command to the predictor and return the result word it should give.
  function automatic edit_result_t apply_edit(cmd_bits_t cmd, char_t ch, pos_t pos);
    edit_result_t res;
    int unsigned  idx;
    res = '0;
    case (cmd)
      gbts_pkg::CMD_INSERT: begin
        if (gap_lo < gap_hi) begin
          text_mirror[gap_lo] = ch;
          gap_lo++;
          res.ok = 1'b1;
        end
      end
      gbts_pkg::CMD_DELETE: begin
        if (gap_lo != 0) begin
          gap_lo--;
          res.ok = 1'b1;
        end
      end
      gbts_pkg::CMD_LEFT: begin
        if (gap_lo != 0 && gap_hi != 0) begin
          gap_hi--;
          gap_lo--;
          text_mirror[gap_hi] = text_mirror[gap_lo];
          res.ok = 1'b1;
        end
      end
      gbts_pkg::CMD_RIGHT: begin
        if (gap_hi < CAP && gap_lo < CAP) begin
          text_mirror[gap_lo] = text_mirror[gap_hi];
          gap_lo++;
          gap_hi++;
          res.ok = 1'b1;
        end
      end
      gbts_pkg::CMD_READ: begin
        if (32'(pos) < text_len_model()) begin
          idx = (32'(pos) < gap_lo) ? 32'(pos) : 32'(pos) + (gap_hi - gap_lo);
          if (idx < CAP) begin
            res.char_out = text_mirror[idx];
            res.ok = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.cursor      = gap_lo[gbts_pkg::COUNT_W-1:0];
    res.text_length = gbts_pkg::COUNT_W'(text_len_model());
    return res;
  endfunction

  // Offer one command word, wait for it to be taken, then record its expected result.
  task automatic send_word(input cmd_bits_t cmd, input char_t ch, input pos_t pos);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tdata  = {{(gbts_pkg::IN_DATA_W - gbts_pkg::CMD_W - gbts_pkg::CHAR_W
                   - gbts_pkg::POS_W){1'b0}}, pos, ch, cmd};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_edit(cmd, ch, pos));
  endtask

  task automatic set_idling(input int unsigned sender_pct, input int unsigned receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
  endtask

  // Empty-store cases, invalid command codes, the byte extremes, moves in the middle and reads past the end.
  task automatic test_directed_edges();
    send_word(gbts_pkg::CMD_DELETE, 8'h00, 12'd0);
    send_word(gbts_pkg::CMD_LEFT, 8'hFF, 12'd0);
    send_word(gbts_pkg::CMD_RIGHT, 8'h00, 12'hFFF);
    send_word(gbts_pkg::CMD_READ, 8'h00, 12'd0);
    send_word(gbts_pkg::CMD_READ, 8'h00, 12'hFFF);
    send_word(3'd5, 8'hFF, 12'hFFF);
    send_word(3'd6, 8'h00, 12'd0);
    send_word(3'd7, 8'h5A, 12'd1);
    send_word(gbts_pkg::CMD_INSERT, 8'h00, 12'hFFF);
    send_word(gbts_pkg::CMD_INSERT, 8'hFF, 12'd0);
    send_word(gbts_pkg::CMD_INSERT, 8'hA5, 12'd0);
    send_word(gbts_pkg::CMD_READ, 8'h00, 12'd0);
    send_word(gbts_pkg::CMD_READ, 8'h00, 12'd1);
    send_word(gbts_pkg::CMD_READ, 8'h00, 12'd2);
    send_word(gbts_pkg::CMD_READ, 8'h00, 12'd3);
    send_word(gbts_pkg::CMD_LEFT, 8'h00, 12'd0);
    send_word(gbts_pkg::CMD_LEFT, 8'h00, 12'd0);
    send_word(gbts_pkg::CMD_INSERT, 8'h3C, 12'd0);
    send_word(gbts_pkg::CMD_READ, 8'h00, 12'd3);
    send_word(gbts_pkg::CMD_RIGHT, 8'h00, 12'd0);
    send_word(gbts_pkg::CMD_DELETE, 8'h00, 12'd0);
    send_word(gbts_pkg::CMD_RIGHT, 8'h00, 12'd0);
    send_word(gbts_pkg::CMD_RIGHT, 8'h00, 12'd0);
    send_word(gbts_pkg::CMD_READ, 8'h00, 12'd2);
  endtask

  // Grow the text, walk the cursor to both ends of it and empty it again.
  task automatic test_fill_and_walk(input int unsigned fill_bytes);
    repeat (fill_bytes) begin
      send_word(gbts_pkg::CMD_INSERT, char_t'($urandom), pos_t'($urandom));
      if ($urandom_range(15) == 0)
        send_word(gbts_pkg::CMD_READ, char_t'($urandom),
                  pos_t'($urandom_range(text_len_model() - 1)));
    end
    send_word(gbts_pkg::CMD_INSERT, 8'hFF, 12'd0);
    send_word(gbts_pkg::CMD_RIGHT, 8'h00, 12'd0);
    send_word(gbts_pkg::CMD_READ, 8'h00, 12'hFFF);
    send_word(gbts_pkg::CMD_READ, 8'h00, 12'd0);
    while (gap_lo > 0) begin
      send_word(gbts_pkg::CMD_LEFT, char_t'($urandom), pos_t'($urandom));
      if ($urandom_range(15) == 0)
        send_word(gbts_pkg::CMD_READ, char_t'($urandom), pos_t'($urandom));
    end
    send_word(gbts_pkg::CMD_LEFT, 8'h00, 12'd0);
    send_word(gbts_pkg::CMD_DELETE, 8'h00, 12'd0);
    send_word(gbts_pkg::CMD_INSERT, 8'h00, 12'd0);
    send_word(gbts_pkg::CMD_READ, 8'h00, 12'hFFF);
    while (gap_hi < CAP) begin
      send_word(gbts_pkg::CMD_RIGHT, char_t'($urandom), pos_t'($urandom));
      if ($urandom_range(15) == 0)
        send_word(gbts_pkg::CMD_READ, char_t'($urandom), pos_t'($urandom));
    end
    while (gap_lo > 0) begin
      send_word(gbts_pkg::CMD_DELETE, char_t'($urandom), pos_t'($urandom));
      if ($urandom_range(15) == 0)
        send_word(gbts_pkg::CMD_READ, char_t'($urandom), pos_t'($urandom));
    end
    send_word(gbts_pkg::CMD_DELETE, 8'h00, 12'd0);
    send_word(gbts_pkg::CMD_READ, 8'h00, 12'd0);
  endtask

  // Mixed editing traffic; reads mostly land inside the text.
  task automatic test_random_edits(input int count);
    int unsigned pick;
    int unsigned len;
    pos_t        pos;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      len  = text_len_model();
      if (len > 0 && $urandom_range(3) != 0)
        pos = pos_t'($urandom_range(len - 1));
      else
        pos = pos_t'($urandom);
      if (pick < 5)
        send_word(cmd_bits_t'($urandom_range(7, 5)), char_t'($urandom), pos);
      else if (pick < 35)
        send_word(gbts_pkg::CMD_INSERT, char_t'($urandom), pos);
      else if (pick < 50)
        send_word(gbts_pkg::CMD_DELETE, char_t'($urandom), pos);
      else if (pick < 65)
        send_word(gbts_pkg::CMD_LEFT, char_t'($urandom), pos);
      else if (pick < 80)
        send_word(gbts_pkg::CMD_RIGHT, char_t'($urandom), pos);
      else
        send_word(gbts_pkg::CMD_READ, char_t'($urandom), pos);
    end
  endtask

  // The receiver stops taking words for a long stretch while commands keep coming.
  task automatic test_output_backpressure();
    hold_req = 1'b1;
    test_random_edits(40);
  endtask

  // Receiver: random idling, or a counted hold-off when one is requested.
  initial begin
    out_tready = 1'b0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else begin
        out_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic void check_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_val, act_val);
      error_count++;
    end
  endfunction

  // Compare every result word taken with the oldest expectation.
  always @(posedge clk) begin
    edit_result_t want;
    edit_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.ok          = out_tdata[0];
      got.char_out    = out_tdata[8:1];
      got.cursor      = out_tdata[21:9];
      got.text_length = out_tdata[34:22];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got 0x%0h", $time, out_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("ok", want.ok, got.ok);
        check_field("char_out", want.char_out, got.char_out);
        check_field("cursor", want.cursor, got.cursor);
        check_field("text_length", want.text_length, got.text_length);
      end
    end
  end

  // Watchdog: too many cycles without any word moving on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        stall_count = 0;
      else
        stall_count++;
      if (stall_count >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    hold_req    = 1'b0;
    error_count = 0;
    stall_count = 0;
    gap_lo      = 0;
    gap_hi      = CAP;
    set_idling(13, 83);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_edges();
    test_random_edits(RANDOM_WORDS);
    set_idling(83, 13);
    test_fill_and_walk(FILL_BYTES);
    test_random_edits(RANDOM_WORDS);
    set_idling(0, 0);
    test_output_backpressure();
    test_random_edits(RANDOM_WORDS);

    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/gbts_pkg.sv
src/gbts_ctrl.sv
src/gbts_dpath.sv
src/gap_buffer_text_store_core.sv
sim/tb_gap_buffer_text_store_core.sv
